FILE: rtl/tlvo_pkg.sv
// Shared types and constants of the TLV option align serializer.
`default_nettype none
package tlvo_pkg;

    // Field widths of the request and response items.
    localparam int REQ_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int MULT_W  = 4;
    localparam int OFF_W   = 3;
    localparam int TOTAL_W = 10;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIX_LENGTHS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_RUN     = 1'd1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_HDR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DATA = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    // Option codes used for padding.
    localparam logic [BYTE_W-1:0] OPT_PAD1 = 8'h00;
    localparam logic [BYTE_W-1:0] OPT_PADN = 8'h01;

    // Largest alignment multiple; larger requests are clamped to it.
    localparam logic [MULT_W-1:0] ALIGN_MAX = 4'd8;

    // Running length after reset and after each list end (two header bytes).
    localparam int RUN_LEN_INIT = 2;

    // Result count and index inside one request (at most nine results).
    localparam int CNT_W = 4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] opt_type;
        logic [BYTE_W-1:0] declared_len;
        logic [BYTE_W-1:0] data_count;
        logic [MULT_W-1:0] align_mult;
        logic [OFF_W-1:0]  align_off;
        logic [BYTE_W-1:0] data_byte;
    } t_req_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last;
        logic               list_done;
        logic [TOTAL_W-1:0] total_len;
        logic               overflow;
    } t_rsp_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_COMMIT,
        ST_EMIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_step;
        logic commit;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic req_none;
        logic need_div;
        logic div_done;
        logic out_free;
        logic emit_last;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: rtl/tlvo_if.sv
// Request and response channel interfaces of the TLV option align serializer.
`default_nettype none
interface tlvo_req_if;
    logic                        valid;
    logic                        ready;
    logic [tlvo_pkg::REQ_W-1:0]  req_type;
    logic [tlvo_pkg::BYTE_W-1:0] opt_type;
    logic [tlvo_pkg::BYTE_W-1:0] declared_len;
    logic [tlvo_pkg::BYTE_W-1:0] data_count;
    logic [tlvo_pkg::MULT_W-1:0] align_mult;
    logic [tlvo_pkg::OFF_W-1:0]  align_off;
    logic [tlvo_pkg::BYTE_W-1:0] data_byte;

    modport source (
        output valid, req_type, opt_type, declared_len, data_count,
               align_mult, align_off, data_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, opt_type, declared_len, data_count,
               align_mult, align_off, data_byte,
        output ready
    );
endinterface

interface tlvo_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tlvo_pkg::BYTE_W-1:0]  out_byte;
    logic                         byte_valid;
    logic                         last;
    logic                         list_done;
    logic [tlvo_pkg::TOTAL_W-1:0] total_len;
    logic                         overflow;

    modport source (
        output valid, out_byte, byte_valid, last, list_done, total_len, overflow,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, last, list_done, total_len, overflow,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/tlvo_ctrl.sv
// Sequencing state machine of the TLV option align serializer.
`default_nettype none
module tlvo_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    input  tlvo_pkg::t_dp_status i_status,
    output logic                 o_req_ready,
    output tlvo_pkg::t_dp_cmd    o_cmd
);
    import tlvo_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (i_status.req_none) begin
                    n_state = ST_IDLE;
                end else if (i_status.need_div) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            ST_PREP: begin
                if (!i_status.req_none) begin
                    o_cmd.div_start = i_status.need_div;
                    o_cmd.commit    = !i_status.need_div;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/tlvo_datapath.sv
// Datapath of the TLV option align serializer: length accounting, divider, byte output.
`default_nettype none
module tlvo_datapath #(
    parameter int LINE_LEN  = 4,
    parameter int MAX_BYTES = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  tlvo_pkg::t_req_item                i_req,
    input  tlvo_pkg::t_dp_cmd                  i_cmd,
    output tlvo_pkg::t_dp_status               o_status,
    input  wire                                i_cfg_we,
    input  wire [tlvo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [tlvo_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output tlvo_pkg::t_rsp_item                o_rsp,
    output logic                               o_rsp_valid,
    input  wire                                i_rsp_ready
);
    import tlvo_pkg::*;

    localparam int LEN_W  = $clog2(MAX_BYTES + 1);
    localparam int SUM_W  = LEN_W + 2;
    localparam int DCNT_W = $clog2(LEN_W);

    // Configuration.
    logic r_fix;
    logic r_dry;

    // Captured request.
    logic [REQ_W-1:0]  r_req;
    logic [BYTE_W-1:0] r_typ;
    logic [BYTE_W-1:0] r_dlen;
    logic [BYTE_W-1:0] r_cnt;
    logic [MULT_W-1:0] r_x;
    logic [OFF_W-1:0]  r_y;
    logic [BYTE_W-1:0] r_db;

    // List state.
    logic [LEN_W-1:0]  r_len;
    logic              r_ovf;
    logic [BYTE_W-1:0] r_remain;

    // Remainder unit.
    logic [LEN_W-1:0]  r_dividend;
    logic [OFF_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;

    // Emission sequence.
    logic [CNT_W-1:0]   r_pad;
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_j;
    logic               r_dok;
    logic [TOTAL_W-1:0] r_total;

    // Output register.
    t_rsp_item r_out;
    logic      r_out_valid;

    logic              need_div;
    logic [MULT_W-1:0] divisor;
    logic [MULT_W-1:0] rem_sh;
    logic [MULT_W-1:0] rem_nx;
    logic [CNT_W-1:0]  rem4;
    logic [CNT_W-1:0]  y4;
    logic [CNT_W-1:0]  pad_h;
    logic [CNT_W-1:0]  pad_e;
    logic [CNT_W-1:0]  pad;
    logic [BYTE_W:0]   body;
    logic [SUM_W-1:0]  sum;
    logic              sat;
    logic [LEN_W-1:0]  len_nx;
    logic [CNT_W-1:0]  k_nx;
    logic [CNT_W-1:0]  j_rel;
    logic              in_pad;
    logic              emit_last;
    logic              out_free;
    t_rsp_item         rsp_nx;

    assign need_div = r_fix && ((r_req == REQ_HDR && r_x != '0) || r_req == REQ_END);
    assign divisor  = (r_req == REQ_END) ? MULT_W'(LINE_LEN) : r_x;

    // One quotient bit per cycle, remainder only.
    always_comb begin
        rem_sh = {r_rem, r_dividend[LEN_W-1]};
        rem_nx = (rem_sh >= divisor) ? rem_sh - divisor : rem_sh;
    end

    // Pad sizes and the new running length, used at commit.
    always_comb begin
        rem4  = {1'b0, r_rem};
        y4    = {1'b0, r_y};
        pad_h = (y4 >= rem4) ? y4 - rem4 : y4 + r_x - rem4;
        pad_e = (r_rem == '0) ? '0 : CNT_W'(LINE_LEN) - rem4;
        if (!need_div) begin
            pad = '0;
        end else if (r_req == REQ_END) begin
            pad = pad_e;
        end else begin
            pad = pad_h;
        end

        if (r_req != REQ_HDR) begin
            body = '0;
        end else if (r_typ == OPT_PAD1) begin
            body = (BYTE_W+1)'(1);
        end else begin
            body = {1'b0, r_cnt} + (BYTE_W+1)'(2);
        end

        sum    = SUM_W'(r_len) + SUM_W'(pad) + SUM_W'(body);
        sat    = sum > SUM_W'(MAX_BYTES);
        len_nx = sat ? LEN_W'(MAX_BYTES) : sum[LEN_W-1:0];

        case (r_req)
            REQ_HDR: begin
                if (r_dry) begin
                    k_nx = CNT_W'(1);
                end else if (r_typ == OPT_PAD1) begin
                    k_nx = pad + CNT_W'(1);
                end else begin
                    k_nx = pad + CNT_W'(2);
                end
            end
            REQ_END: begin
                k_nx = (r_dry || pad == '0) ? CNT_W'(1) : pad;
            end
            default: begin
                k_nx = CNT_W'(1);
            end
        endcase
    end

    // Next result from the emission index.
    always_comb begin
        j_rel     = r_j - r_pad;
        in_pad    = !r_dry && (r_j < r_pad);
        emit_last = (r_j == r_k - CNT_W'(1));
        out_free  = !r_out_valid || i_rsp_ready;

        rsp_nx            = '0;
        rsp_nx.last       = emit_last;
        rsp_nx.overflow   = r_ovf;
        rsp_nx.list_done  = emit_last && (r_req == REQ_END);
        rsp_nx.total_len  = rsp_nx.list_done ? r_total : '0;
        if (in_pad) begin
            rsp_nx.byte_valid = 1'b1;
            if (r_j == '0 && r_pad >= CNT_W'(2)) begin
                rsp_nx.out_byte = OPT_PADN;
            end else if (r_j == CNT_W'(1)) begin
                rsp_nx.out_byte = BYTE_W'(r_pad - CNT_W'(2));
            end else begin
                rsp_nx.out_byte = OPT_PAD1;
            end
        end else begin
            case (r_req)
                REQ_HDR: begin
                    rsp_nx.byte_valid = !r_dry;
                    if (r_dry) begin
                        rsp_nx.out_byte = '0;
                    end else if (j_rel == '0) begin
                        rsp_nx.out_byte = r_typ;
                    end else begin
                        rsp_nx.out_byte = r_fix ? r_cnt : r_dlen;
                    end
                end
                REQ_DATA: begin
                    rsp_nx.byte_valid = r_dok && !r_dry;
                    rsp_nx.out_byte   = (r_dok && !r_dry) ? r_db : '0;
                end
                default: begin
                    rsp_nx.byte_valid = 1'b0;
                    rsp_nx.out_byte   = '0;
                end
            endcase
        end
    end

    always_comb begin
        o_status.req_none  = (r_req == REQ_NONE);
        o_status.need_div  = need_div;
        o_status.div_done  = (r_dcnt == DCNT_W'(LEN_W - 1));
        o_status.out_free  = out_free;
        o_status.emit_last = emit_last;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix       <= 1'b1;
            r_dry       <= 1'b0;
            r_len       <= LEN_W'(RUN_LEN_INIT);
            r_ovf       <= 1'b0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIX_LENGTHS: r_fix <= i_cfg_wdata[0];
                    CFG_DRY_RUN:     r_dry <= i_cfg_wdata[0];
                    default:         r_fix <= r_fix;
                endcase
            end

            if (i_cmd.commit) begin
                r_len <= len_nx;
                if (sat) begin
                    r_ovf <= 1'b1;
                end
                case (r_req)
                    REQ_HDR:  r_remain <= (r_typ == OPT_PAD1) ? '0 : r_cnt;
                    REQ_DATA: r_remain <= (r_remain != '0) ? r_remain - 1'b1 : r_remain;
                    default:  r_remain <= '0;
                endcase
            end

            // A list end starts a new list once its last result is out.
            if (i_cmd.emit && emit_last && r_req == REQ_END) begin
                r_len <= LEN_W'(RUN_LEN_INIT);
                r_ovf <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req.req_type;
            r_typ  <= i_req.opt_type;
            r_dlen <= i_req.declared_len;
            r_cnt  <= i_req.data_count;
            r_x    <= (i_req.align_mult > ALIGN_MAX) ? ALIGN_MAX : i_req.align_mult;
            r_y    <= i_req.align_off;
            r_db   <= i_req.data_byte;
        end

        if (i_cmd.div_start) begin
            r_dividend <= r_len;
            r_rem      <= '0;
            r_dcnt     <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= rem_nx[OFF_W-1:0];
            r_dcnt     <= r_dcnt + 1'b1;
        end

        if (i_cmd.commit) begin
            r_pad   <= pad;
            r_k     <= k_nx;
            r_j     <= '0;
            r_dok   <= (r_remain != '0);
            r_total <= TOTAL_W'(len_nx - LEN_W'(RUN_LEN_INIT));
        end else if (i_cmd.emit) begin
            r_j <= r_j + 1'b1;
        end

        if (i_cmd.emit) begin
            r_out <= rsp_nx;
        end
    end

    assign o_rsp       = r_out;
    assign o_rsp_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: rtl/tlv_option_align_serializer.sv
// Top level of the TLV option align serializer.
//
// Requests arrive on i_req_ch: an option header, one option data byte, or an
// end of list. Each request produces one to nine responses on o_rsp_ch, the
// last one flagged by last; the final response of an end of list carries
// list_done and total_len. Both channels use a valid/ready handshake.
// Options are aligned with Pad1 or PadN when fix_lengths is set, and the list
// end is padded to a multiple of LINE_LEN. Dry run keeps only the lengths.
//
// Sequence: a data request or an unaligned header is captured, committed
// and loaded into the output register, then one response per cycle follows
// while the receiver takes them. An aligned header or a padded list end
// first runs the running length through a one-bit-per-cycle remainder unit
// before commit. One request is in flight at a time; a new request is
// accepted in the cycle after the last response of the previous one has
// been loaded, while that response still waits in the output register.
// Reset returns the running length to 2, clears the overflow flag, sets
// fix_lengths and clears dry_run. A stalled receiver holds the output
// register and pauses the sequence; nothing is dropped.
`default_nettype none
module tlv_option_align_serializer #(
    parameter int LINE_LEN  = 4,
    parameter int MAX_BYTES = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    tlvo_req_if.sink                           i_req_ch,
    tlvo_rsp_if.source                         o_rsp_ch,
    input  wire                                i_cfg_we,
    input  wire [tlvo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [tlvo_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import tlvo_pkg::*;

    t_req_item  req;
    t_rsp_item  rsp;
    logic       rsp_valid;
    logic       req_ready;
    t_dp_cmd    cmd;
    t_dp_status status;

    // Gather the request fields into one item for the datapath.
    always_comb begin
        req.req_type     = i_req_ch.req_type;
        req.opt_type     = i_req_ch.opt_type;
        req.declared_len = i_req_ch.declared_len;
        req.data_count   = i_req_ch.data_count;
        req.align_mult   = i_req_ch.align_mult;
        req.align_off    = i_req_ch.align_off;
        req.data_byte    = i_req_ch.data_byte;
    end

    assign i_req_ch.ready = req_ready;

    // The controller sequences capture, remainder steps, commit and emission.
    tlvo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_ch.valid),
        .i_status    (status),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the list state and the output register.
    tlvo_datapath #(
        .LINE_LEN  (LINE_LEN),
        .MAX_BYTES (MAX_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (rsp),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp_ch.ready)
    );

    assign o_rsp_ch.valid      = rsp_valid;
    assign o_rsp_ch.out_byte   = rsp.out_byte;
    assign o_rsp_ch.byte_valid = rsp.byte_valid;
    assign o_rsp_ch.last       = rsp.last;
    assign o_rsp_ch.list_done  = rsp.list_done;
    assign o_rsp_ch.total_len  = rsp.total_len;
    assign o_rsp_ch.overflow   = rsp.overflow;

    // A list end is always the last response of its request.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_ch.valid && o_rsp_ch.list_done) |-> o_rsp_ch.last)
        else $error("list_done without last");

    // The total length is reported only with a list end.
    a_total_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_ch.valid && o_rsp_ch.total_len != '0) |-> o_rsp_ch.list_done)
        else $error("total_len set outside list end");

    // A response is loaded only when the output register can take it.
    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("response loaded over a waiting one");

    // A new request is never taken while a sequence is in progress.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_ch.valid && i_req_ch.ready) |=>
            !(cmd.div_step || cmd.emit || cmd.capture))
        else $error("request accepted mid-sequence");

endmodule
`default_nettype wire
